// ===== src/mas_pkg.sv =====
// Shared types, codes and helper functions for the motion alarm sequencer.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SENS_W   = 4;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Phase codes.
    localparam logic [MODE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] PH_DETECTED = 3'd1;
    localparam logic [MODE_W-1:0] PH_ALARM    = 3'd2;
    localparam logic [MODE_W-1:0] PH_RECORD   = 3'd3;
    localparam logic [MODE_W-1:0] PH_COOLDOWN = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_TIME   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [SENS_W-1:0] SENS_RESET       = 4'd5;
    localparam logic [SENS_W-1:0] SENS_MIN         = 4'd1;
    localparam logic [SENS_W-1:0] SENS_MAX         = 4'd10;
    localparam logic [TIME_W-1:0] ALARM_TIME_RESET = 32'd5000;
    localparam logic [TIME_W-1:0] RECORD_TIME_RESET = 32'd30000;
    localparam logic [TIME_W-1:0] COOL_TIME_RESET  = 32'd10000;

    localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

    typedef struct packed {
        logic              motion_level;
        logic [TIME_W-1:0] now_ms;
    } t_mas_in;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               buzzer_on;
        logic               red_led_on;
        logic               green_led_on;
        logic               camera_trigger;
        logic               alarm_flag;
        logic               recording_flag;
        logic [COUNT_W-1:0] motion_total;
    } t_mas_out;

    typedef struct packed {
        logic [SENS_W-1:0] sensitivity;
        logic [TIME_W-1:0] alarm_time_ms;
        logic [TIME_W-1:0] record_time_ms;
        logic [TIME_W-1:0] cooldown_time_ms;
    } t_mas_cfg;

    // Clamp a written sensitivity value into 1..10.
    function automatic logic [SENS_W-1:0] clamp_sens(input logic [SENS_W-1:0] value);
        logic [SENS_W-1:0] s;
        s = value;
        if (s < SENS_MIN) s = SENS_MIN;
        if (s > SENS_MAX) s = SENS_MAX;
        return s;
    endfunction

    // Debounce threshold clamp((11 - s) / 2, 1, 5) as a small table.
    function automatic logic [RUN_W-1:0] debounce_limit(input logic [SENS_W-1:0] sens);
        logic [RUN_W-1:0] lim;
        unique case (sens)
            4'd0, 4'd1:         lim = 3'd5;
            4'd2, 4'd3:         lim = 3'd4;
            4'd4, 4'd5:         lim = 3'd3;
            4'd6, 4'd7:         lim = 3'd2;
            default:            lim = 3'd1;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== src/motion_alarm_sequencer_core.sv =====
// Top level of the motion alarm sequencer: configuration registers, sequencer, result queue.
// Depends on mas_pkg, mas_ctrl and mas_outq.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-------------------------------
// poll in   | in        | i_in_valid / o_in_stall | i_in_item  (mas_pkg::t_mas_in)
// result    | out       | o_out_valid / i_out_stall | o_out_item (mas_pkg::t_mas_out)
// config    | in        | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// An accepted item is registered, then its phase update and result are computed in
// the next cycle and written into a three-entry result queue, so its result is
// held in the input register and then a queue entry before it can be taken. One
// item is taken every cycle while the input does not stall. The input stalls only
// when the queue plus the item in flight fill all three entries, which happens only
// when the output side stalls. Reset is synchronous and active low; it restores the
// configuration defaults and the idle phase and empties the queue.
module motion_alarm_sequencer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire mas_pkg::t_mas_in                i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output mas_pkg::t_mas_out                    o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [mas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mas_pkg::TIME_W-1:0]      i_cfg_data
);
    import mas_pkg::*;

    t_mas_cfg   r_cfg;
    logic       in_accept;
    logic       res_valid;
    t_mas_out   res;
    logic [1:0] q_count;

    // Configuration registers. Sensitivity writes are clamped into the legal range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity      <= SENS_RESET;
            r_cfg.alarm_time_ms    <= ALARM_TIME_RESET;
            r_cfg.record_time_ms   <= RECORD_TIME_RESET;
            r_cfg.cooldown_time_ms <= COOL_TIME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSITIVITY: r_cfg.sensitivity      <= clamp_sens(i_cfg_data[SENS_W-1:0]);
                CFG_ALARM_TIME:  r_cfg.alarm_time_ms    <= i_cfg_data;
                CFG_RECORD_TIME: r_cfg.record_time_ms   <= i_cfg_data;
                CFG_COOL_TIME:   r_cfg.cooldown_time_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The queue count plus the item in flight never exceeds three, so this stall
    // guarantees the in-flight item always finds a free entry.
    assign o_in_stall = ({1'b0, q_count} + {2'b00, res_valid}) >= 3'd3;
    assign in_accept  = i_in_valid && !o_in_stall;

    mas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mas_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .o_count (q_count)
    );

endmodule

`default_nettype wire

// ===== src/mas_ctrl.sv =====
// Poll register and phase sequencer: debounce, timers, flags and event count.
// Depends on mas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mas_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire mas_pkg::t_mas_in  i_item,
    input  wire mas_pkg::t_mas_cfg i_cfg,
    output logic                  o_res_valid,
    output mas_pkg::t_mas_out     o_res
);
    import mas_pkg::*;

    logic               r_in_valid;
    t_mas_in            r_in;

    logic [MODE_W-1:0]  r_phase,  n_phase;
    logic [TIME_W-1:0]  r_entry,  n_entry;
    logic [RUN_W-1:0]   r_run,    n_run;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_drives, n_drives;
    logic               r_alarm,  n_alarm;
    logic               r_record, n_record;

    logic [TIME_W-1:0]  elapsed;
    logic [RUN_W-1:0]   run_inc;
    logic               qualify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
        if (i_accept) begin
            r_in <= i_item;
        end
    end

    // Debounce: the run of high polls saturates, and reaching the limit qualifies.
    always_comb begin
        if (r_in.motion_level) begin
            run_inc = (r_run == RUN_MAX) ? RUN_MAX : r_run + RUN_W'(1);
        end else begin
            run_inc = '0;
        end
        qualify = (run_inc >= debounce_limit(i_cfg.sensitivity));
        elapsed = r_in.now_ms - r_entry;
    end

    always_comb begin
        n_phase  = r_phase;
        n_entry  = r_entry;
        n_run    = r_run;
        n_count  = r_count;
        n_drives = r_drives;
        n_alarm  = r_alarm;
        n_record = r_record;
        unique case (r_phase)
            PH_DETECTED: begin
                n_drives = 1'b1;
                n_alarm  = 1'b1;
                n_record = 1'b0;
                n_phase  = PH_ALARM;
                n_entry  = r_in.now_ms;
            end
            PH_ALARM: begin
                if (elapsed >= i_cfg.alarm_time_ms) begin
                    n_phase  = PH_RECORD;
                    n_entry  = r_in.now_ms;
                    n_record = 1'b1;
                end
            end
            PH_RECORD: begin
                if (elapsed >= i_cfg.record_time_ms) begin
                    n_phase  = PH_COOLDOWN;
                    n_entry  = r_in.now_ms;
                    n_record = 1'b0;
                end
            end
            PH_COOLDOWN: begin
                n_run = qualify ? '0 : run_inc;
                if (qualify) begin
                    n_count = r_count + COUNT_W'(1);
                    n_entry = r_in.now_ms;
                end
                // The end test uses the elapsed time from the old entry stamp.
                if (elapsed >= i_cfg.cooldown_time_ms) begin
                    n_drives = 1'b0;
                    n_alarm  = 1'b0;
                    n_record = 1'b0;
                    n_phase  = PH_IDLE;
                    n_entry  = r_in.now_ms;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_run   = qualify ? '0 : run_inc;
                if (qualify) begin
                    n_count = r_count + COUNT_W'(1);
                    n_phase = PH_DETECTED;
                    n_entry = r_in.now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_entry  <= '0;
            r_run    <= '0;
            r_count  <= '0;
            r_drives <= 1'b0;
            r_alarm  <= 1'b0;
            r_record <= 1'b0;
        end else if (r_in_valid) begin
            r_phase  <= n_phase;
            r_entry  <= n_entry;
            r_run    <= n_run;
            r_count  <= n_count;
            r_drives <= n_drives;
            r_alarm  <= n_alarm;
            r_record <= n_record;
        end
    end

    always_comb begin
        o_res_valid          = r_in_valid;
        o_res.mode           = n_phase;
        o_res.buzzer_on      = n_drives;
        o_res.red_led_on     = n_drives;
        o_res.green_led_on   = ~n_drives;
        o_res.camera_trigger = n_drives;
        o_res.alarm_flag     = n_alarm;
        o_res.recording_flag = n_record;
        o_res.motion_total   = n_count;
    end

endmodule

`default_nettype wire

// ===== src/mas_outq.sv =====
// Three-entry result queue that decouples the sequencer from output stalls.
// Depends on mas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mas_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mas_pkg::t_mas_out i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output mas_pkg::t_mas_out      o_data,
    output logic [1:0]             o_count
);
    import mas_pkg::*;

    localparam logic [1:0] LAST = 2'd2;

    t_mas_out   r_mem [3];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign do_pop  = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/mas_checker.sv =====
// Port-level checks for the motion alarm sequencer, bound to the top level.
// Depends on mas_pkg and motion_alarm_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none

module mas_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire mas_pkg::t_mas_out o_out_item
);
    import mas_pkg::*;

    // No result may be offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // The drives follow the alarm flag, and green is the inverse of the buzzer.
    a_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.buzzer_on == o_out_item.alarm_flag) &&
                        (o_out_item.green_led_on != o_out_item.buzzer_on) &&
                        (o_out_item.red_led_on == o_out_item.buzzer_on) &&
                        (o_out_item.camera_trigger == o_out_item.buzzer_on))
        else $error("drive lines disagree with alarm flag");

    // Recording is flagged exactly in the recording phase.
    a_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.recording_flag == (o_out_item.mode == PH_RECORD)))
        else $error("recording flag outside recording phase");

    // Idle and detected phases never show the alarm active; the others always do.
    a_alarm_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.alarm_flag ==
                         ((o_out_item.mode == PH_ALARM) || (o_out_item.mode == PH_RECORD) ||
                          (o_out_item.mode == PH_COOLDOWN))))
        else $error("alarm flag does not match phase");

endmodule

bind motion_alarm_sequencer_core mas_checker u_mas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== tb/tb_motion_alarm_sequencer_core.sv =====
// Self-checking testbench for motion_alarm_sequencer_core: timed motion polls and
// register settings are checked against an in-bench model of the alarm sequencer.
// Depends on mas_pkg and the RTL in src; it reads no files.
`timescale 1ns / 1ps

module tb_motion_alarm_sequencer_core;
    import mas_pkg::*;

    localparam int unsigned CLK_HALF_NS     = 5;
    localparam int unsigned TIMEOUT_NS      = 5_000_000;
    localparam int unsigned ROUNDS          = 8;
    localparam int unsigned POLLS_PER_ROUND = 85;
    localparam int unsigned MAX_WAIT        = 12;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned PRINT_CAP       = 40;

    // Model of the sequencer. It keeps its own copy of the registers and of the
    // sequencer state, predicts the status of every accepted poll and holds the
    // predictions in arrival order until the matching result comes out.
    class alarm_status_tracker;
        logic [SENS_W-1:0]  sens;
        logic [TIME_W-1:0]  alarm_ms;
        logic [TIME_W-1:0]  record_ms;
        logic [TIME_W-1:0]  cool_ms;
        logic [MODE_W-1:0]  phase;
        logic [TIME_W-1:0]  entry_ms;
        logic [RUN_W-1:0]   high_run;
        logic [COUNT_W-1:0] events;
        logic               drives;
        logic               alarm_on;
        logic               record_on;
        t_mas_out           predicted_status[$];

        function new();
            sens      = SENS_RESET;
            alarm_ms  = ALARM_TIME_RESET;
            record_ms = RECORD_TIME_RESET;
            cool_ms   = COOL_TIME_RESET;
            phase     = PH_IDLE;
            entry_ms  = '0;
            high_run  = '0;
            events    = '0;
            drives    = 1'b0;
            alarm_on  = 1'b0;
            record_on = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
            logic [SENS_W-1:0] s;
            s = data[SENS_W-1:0];
            case (idx)
                CFG_SENSITIVITY: begin
                    if (s < SENS_MIN) s = SENS_MIN;
                    if (s > SENS_MAX) s = SENS_MAX;
                    sens = s;
                end
                CFG_ALARM_TIME:  alarm_ms = data;
                CFG_RECORD_TIME: record_ms = data;
                default:         cool_ms = data;
            endcase
        endfunction

        // Time at which the current timed phase would run out.
        function logic [TIME_W-1:0] deadline();
            case (phase)
                PH_ALARM:    return entry_ms + alarm_ms;
                PH_RECORD:   return entry_ms + record_ms;
                PH_COOLDOWN: return entry_ms + cool_ms;
                default:     return entry_ms;
            endcase
        endfunction

        // Debounce: count consecutive high polls; true when the run reaches the
        // threshold set by the sensitivity, which also bumps the event count.
        function bit take_motion(logic level);
            int lim;
            if (level) begin
                if (high_run != RUN_MAX) high_run = high_run + 1'b1;
            end else begin
                high_run = '0;
            end
            lim = (11 - int'(sens)) / 2;
            if (lim < 1) lim = 1;
            if (lim > 5) lim = 5;
            if (int'(high_run) >= lim) begin
                high_run = '0;
                events   = events + 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void predict_poll_status(t_mas_in poll);
            logic [TIME_W-1:0] elapsed;
            t_mas_out          status;
            // Elapsed time is taken once, from the entry time before this poll.
            elapsed = poll.now_ms - entry_ms;
            case (phase)
                PH_DETECTED: begin
                    drives    = 1'b1;
                    alarm_on  = 1'b1;
                    record_on = 1'b0;
                    phase     = PH_ALARM;
                    entry_ms  = poll.now_ms;
                end
                PH_ALARM: begin
                    if (elapsed >= alarm_ms) begin
                        phase     = PH_RECORD;
                        entry_ms  = poll.now_ms;
                        record_on = 1'b1;
                    end
                end
                PH_RECORD: begin
                    if (elapsed >= record_ms) begin
                        phase     = PH_COOLDOWN;
                        entry_ms  = poll.now_ms;
                        record_on = 1'b0;
                    end
                end
                PH_COOLDOWN: begin
                    if (take_motion(poll.motion_level)) entry_ms = poll.now_ms;
                    if (elapsed >= cool_ms) begin
                        drives    = 1'b0;
                        alarm_on  = 1'b0;
                        record_on = 1'b0;
                        phase     = PH_IDLE;
                        entry_ms  = poll.now_ms;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (take_motion(poll.motion_level)) begin
                        phase    = PH_DETECTED;
                        entry_ms = poll.now_ms;
                    end
                end
            endcase
            status.mode           = phase;
            status.buzzer_on      = drives;
            status.red_led_on     = drives;
            status.green_led_on   = !drives;
            status.camera_trigger = drives;
            status.alarm_flag     = alarm_on;
            status.recording_flag = record_on;
            status.motion_total   = events;
            predicted_status.push_back(status);
        endfunction

        // Returns nonzero and a description when the result does not match the
        // oldest prediction, or when no prediction is waiting.
        function int check_status(t_mas_out got, output string why);
            t_mas_out want;
            why = "";
            if (predicted_status.size() == 0) begin
                why = $sformatf(" unexpected result %h", got);
                return 1;
            end
            want = predicted_status.pop_front();
            if (got.mode !== want.mode)
                why = {why, $sformatf(" mode %0d want %0d", got.mode, want.mode)};
            if (got.buzzer_on !== want.buzzer_on)
                why = {why, $sformatf(" buzzer %b want %b", got.buzzer_on, want.buzzer_on)};
            if (got.red_led_on !== want.red_led_on)
                why = {why, $sformatf(" red %b want %b", got.red_led_on, want.red_led_on)};
            if (got.green_led_on !== want.green_led_on)
                why = {why, $sformatf(" green %b want %b", got.green_led_on,
                                      want.green_led_on)};
            if (got.camera_trigger !== want.camera_trigger)
                why = {why, $sformatf(" camera %b want %b", got.camera_trigger,
                                      want.camera_trigger)};
            if (got.alarm_flag !== want.alarm_flag)
                why = {why, $sformatf(" alarm %b want %b", got.alarm_flag, want.alarm_flag)};
            if (got.recording_flag !== want.recording_flag)
                why = {why, $sformatf(" recording %b want %b", got.recording_flag,
                                      want.recording_flag)};
            if (got.motion_total !== want.motion_total)
                why = {why, $sformatf(" total %0d want %0d", got.motion_total,
                                      want.motion_total)};
            return (why != "") ? 1 : 0;
        endfunction

        function int pending();
            return predicted_status.size();
        endfunction
    endclass

    // Every input of the block starts at a known value; reset is held low at start.
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_mas_in              in_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_mas_out             out_item;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [TIME_W-1:0]    cfg_data = '0;

    alarm_status_tracker  tracker;
    int                   fail_count = 0;
    int unsigned          gap_max    = 0;
    int unsigned          stall_max  = 0;
    int unsigned          stall_left = 0;
    int unsigned          motion_pct = 50;
    logic [TIME_W-1:0]    now_cur    = '0;

    motion_alarm_sequencer_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    task automatic report_mismatch(input string why);
        fail_count++;
        if (fail_count <= PRINT_CAP) $display("%0t ns: status mismatch:%s", $time, why);
    endtask

    // Result side. Every value read here is the one from before the edge, since the
    // block and the testbench both update through nonblocking assignments. After
    // each result taken a fresh stall length is drawn, so stalls land anywhere in
    // the sequencer's work; a stall length of zero keeps the receiver wide open.
    always @(posedge clk) begin
        string why;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (tracker.check_status(out_item, why) != 0) report_mismatch(why);
                stall_left = $urandom_range(0, stall_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Offer one poll after a random gap and hold it until it is accepted. Valid is
    // left high afterwards, so back-to-back polls never drop it for a step.
    task automatic send_poll(input t_mas_in poll);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= poll;
        do @(posedge clk); while (in_stall);
        tracker.predict_poll_status(poll);
    endtask

    // Stop offering polls and wait until every predicted status has come out. Each
    // poll gives exactly one result, so nothing is left in flight after this.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    // One register write per edge; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [TIME_W-1:0] sens_word,
                                input logic [TIME_W-1:0] alarm_word,
                                input logic [TIME_W-1:0] record_word,
                                input logic [TIME_W-1:0] cool_word);
        write_reg(CFG_SENSITIVITY, sens_word);
        write_reg(CFG_ALARM_TIME, alarm_word);
        write_reg(CFG_RECORD_TIME, record_word);
        write_reg(CFG_COOL_TIME, cool_word);
        cfg_we <= 1'b0;
    endtask

    // Phase durations: mostly short so the sequencer cycles through all phases,
    // with zero, the full 32-bit value and arbitrary values mixed in.
    function automatic logic [TIME_W-1:0] pick_period();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom_range(0, 40);
        else if (roll < 60) return '0;
        else if (roll < 70) return '1;
        else if (roll < 85) return $urandom_range(0, 3000);
        else return $urandom();
    endfunction

    // Timestamps mostly move forward in small steps. About a quarter land right
    // around the end of the current timed phase, which is what lets long or
    // maximal durations expire; a few jump anywhere, wrapping the clock.
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return now_cur + $urandom_range(0, 20);
        else if (roll < 80) return tracker.deadline() + $urandom_range(0, 2) - 1;
        else if (roll < 93) return now_cur + $urandom_range(0, 5000);
        else return $urandom();
    endfunction

    task automatic send_random_poll();
        t_mas_in poll;
        poll.motion_level = ($urandom_range(0, 99) < motion_pct);
        poll.now_ms       = pick_time();
        now_cur           = poll.now_ms;
        send_poll(poll);
    endtask

    // Directed walk with the reset settings (threshold three polls, alarm 5000,
    // recording 30000, cooldown 10000). Times are given relative to the entry
    // time of the current phase, so each step hits its boundary exactly.
    task automatic run_directed();
        logic              lvl  [25];
        logic [TIME_W-1:0] dt   [25];
        t_mas_in           poll;
        // Idle: one quiet poll, then a qualifying run of three to detected.
        lvl[0]  = 1'b0; dt[0]  = 32'd0;
        lvl[1]  = 1'b1; dt[1]  = 32'd1;
        lvl[2]  = 1'b1; dt[2]  = 32'd2;
        lvl[3]  = 1'b1; dt[3]  = 32'd3;
        // Detected lasts one poll, then alarm ends exactly at its duration.
        lvl[4]  = 1'b0; dt[4]  = 32'd7;
        lvl[5]  = 1'b1; dt[5]  = 32'd4999;
        lvl[6]  = 1'b0; dt[6]  = 32'd5000;
        lvl[7]  = 1'b0; dt[7]  = 32'd29999;
        lvl[8]  = 1'b1; dt[8]  = 32'd30000;
        // Cooldown: motion restarts the timer; later a qualifying poll lands on the
        // same poll as the end of cooldown, which still uses the old entry time.
        lvl[9]  = 1'b1; dt[9]  = 32'd1;
        lvl[10] = 1'b1; dt[10] = 32'd2;
        lvl[11] = 1'b1; dt[11] = 32'd9999;
        lvl[12] = 1'b1; dt[12] = 32'd9999;
        lvl[13] = 1'b1; dt[13] = 32'd9999;
        lvl[14] = 1'b1; dt[14] = 32'd10000;
        // Back in idle: a broken run, then a clean one.
        lvl[15] = 1'b1; dt[15] = 32'd5;
        lvl[16] = 1'b0; dt[16] = 32'd6;
        lvl[17] = 1'b1; dt[17] = 32'd7;
        lvl[18] = 1'b1; dt[18] = 32'd8;
        lvl[19] = 1'b1; dt[19] = 32'd9;
        // Largest elapsed time in every timed phase, wrapping the clock.
        lvl[20] = 1'b0; dt[20] = 32'd0;
        lvl[21] = 1'b0; dt[21] = '1;
        lvl[22] = 1'b0; dt[22] = '1;
        lvl[23] = 1'b1; dt[23] = 32'd0;
        lvl[24] = 1'b1; dt[24] = '1;
        for (int k = 0; k < 25; k++) begin
            poll.motion_level = lvl[k];
            poll.now_ms       = tracker.entry_ms + dt[k];
            now_cur           = poll.now_ms;
            send_poll(poll);
        end
    endtask

    initial begin
        logic [TIME_W-1:0] sens_word;
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        gap_max   = 3;
        stall_max = 3;
        run_directed();

        // Each round runs with its own registers, idle pattern and motion density.
        // Registers change only once the block has drained. The first two rounds
        // take the extremes: sensitivity written as 0 and as 15 (clamped to the
        // ends of the range), and all durations zero or all at the maximum.
        for (int round = 0; round < ROUNDS; round++) begin
            wait_drained();
            if (round == 0) begin
                program_regs('0, '0, '0, '0);
            end else if (round == 1) begin
                program_regs(32'hFFFF_FFFF, '1, '1, '1);
            end else begin
                sens_word = $urandom();
                sens_word[SENS_W-1:0] = SENS_W'($urandom_range(0, 15));
                program_regs(sens_word, pick_period(), pick_period(), pick_period());
            end
            // Round zero runs with no idling on either side.
            if (round == 0) begin
                gap_max   = 0;
                stall_max = 0;
            end else begin
                gap_max   = $urandom_range(0, 1) ? MAX_WAIT : $urandom_range(0, 4);
                stall_max = $urandom_range(0, 1) ? MAX_WAIT : $urandom_range(0, 4);
            end
            motion_pct = $urandom_range(20, 90);
            if ($urandom_range(0, 3) == 0) now_cur = 32'hFFFF_FFF0;
            for (int n = 0; n < POLLS_PER_ROUND; n++) begin
                // Once, the sender holds off until every result has come out.
                if (round == 3 && n == POLLS_PER_ROUND / 2) wait_drained();
                send_random_poll();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending() != 0) report_mismatch(" polls left without a result");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
